// ===== hdl/hde_pkg.sv =====
// Shared types, constants and the arctangent table for the haversine distance unit.
`default_nettype none
package hde_pkg;
  typedef logic signed [31:0] q30_t;
  typedef logic signed [33:0] cw_t;

  localparam int CORDIC_STEPS = 31;
  localparam int SC_LAT       = 35;
  localparam int MQ_LAT       = 6;
  localparam int ANG_LAT      = 63;

  localparam cw_t CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [31:0] FULL_TURN_H    = 32'sd720000000;
  localparam logic signed [31:0] HALF_TURN_H    = 32'sd360000000;
  localparam logic signed [31:0] QUARTER_TURN_H = 32'sd180000000;
  localparam logic [63:0] RAD_SCALE = 64'h3243F6A8885A308D / 64'd90000000;
  localparam q30_t Q_ONE = 32'sd1073741824;
  localparam logic [60:0] Q_ONE_SQ = 61'h1000_0000_0000_0000;
  localparam logic [12:0] RADIUS_RESET = 13'd6371;

  function automatic cw_t atan_q30(input int idx);
    cw_t v;
    case (idx)
      0: v = 34'sd843314857;
      1: v = 34'sd497837829;
      2: v = 34'sd263043837;
      3: v = 34'sd133525159;
      4: v = 34'sd67021687;
      5: v = 34'sd33543516;
      6: v = 34'sd16775851;
      7: v = 34'sd8388437;
      8: v = 34'sd4194283;
      9: v = 34'sd2097149;
      default: v = (idx < CORDIC_STEPS) ? (34'sd1 <<< (30 - idx)) : 34'sd0;
    endcase
    return v;
  endfunction

  function automatic q30_t clamp_q30(input cw_t v);
    q30_t r;
    if (v > 34'sd1073741824) begin
      r = Q_ONE;
    end else if (v < -34'sd1073741824) begin
      r = -Q_ONE;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== hdl/hde_sincos.sv =====
// Pipelined angle reduction and rotation CORDIC giving sine and cosine in Q30.
`default_nettype none
module hde_sincos import hde_pkg::*; (
  input  wire logic               clk,
  input  wire logic               ce,
  input  wire logic signed [30:0] h_i,
  output q30_t                    sin_o,
  output q30_t                    cos_o
);
  logic signed [31:0] hx, r1, r2;
  logic        flip_nxt;
  logic [27:0] mag_nxt;
  logic [27:0] mag1_r;
  logic        neg1_r, flip1_r;
  logic [45:0] pl2_r, ph2_r;
  logic        neg2_r, flip2_r;
  logic [63:0] sum3;
  cw_t         z0_nxt;
  cw_t         z0_r;
  logic        flip3_r;
  cw_t         cx_r [0:CORDIC_STEPS-1];
  cw_t         cy_r [0:CORDIC_STEPS-1];
  cw_t         cz_r [0:CORDIC_STEPS-1];
  logic        cf_r [0:CORDIC_STEPS-1];
  q30_t        sin_r, cos_r;

  assign hx = {h_i[30], h_i};

  // Wrap to (-180, 180] degrees, then fold into [-90, 90] with a cosine flip.
  always_comb begin
    if (hx == -HALF_TURN_H) begin
      r1 = HALF_TURN_H;
    end else if (hx > HALF_TURN_H) begin
      r1 = hx - FULL_TURN_H;
    end else if (hx < -HALF_TURN_H) begin
      r1 = hx + FULL_TURN_H;
    end else begin
      r1 = hx;
    end
    flip_nxt = 1'b0;
    if (r1 > QUARTER_TURN_H) begin
      r2 = HALF_TURN_H - r1;
      flip_nxt = 1'b1;
    end else if (r1 < -QUARTER_TURN_H) begin
      r2 = -HALF_TURN_H - r1;
      flip_nxt = 1'b1;
    end else begin
      r2 = r1;
    end
    mag_nxt = r2[31] ? 28'(-r2) : r2[27:0];
  end

  assign sum3   = {ph2_r, 18'd0} + 64'(pl2_r) + 64'h0000_0000_8000_0000;
  assign z0_nxt = neg2_r ? -$signed({2'b00, sum3[63:32]}) : $signed({2'b00, sum3[63:32]});

  always_ff @(posedge clk) begin
    if (ce) begin
      mag1_r  <= mag_nxt;
      neg1_r  <= r2[31];
      flip1_r <= flip_nxt;
      pl2_r   <= 46'(mag1_r) * 46'(RAD_SCALE[17:0]);
      ph2_r   <= 46'(mag1_r) * 46'(RAD_SCALE[35:18]);
      neg2_r  <= neg1_r;
      flip2_r <= flip1_r;
      z0_r    <= z0_nxt;
      flip3_r <= flip2_r;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    cw_t  xp, yp, zp, x_nxt, y_nxt, z_nxt;
    logic fp;
    if (i == 0) begin : g_first
      assign xp = CORDIC_GAIN;
      assign yp = '0;
      assign zp = z0_r;
      assign fp = flip3_r;
    end else begin : g_next
      assign xp = cx_r[i-1];
      assign yp = cy_r[i-1];
      assign zp = cz_r[i-1];
      assign fp = cf_r[i-1];
    end
    assign x_nxt = zp[33] ? xp + (yp >>> i) : xp - (yp >>> i);
    assign y_nxt = zp[33] ? yp - (xp >>> i) : yp + (xp >>> i);
    assign z_nxt = zp[33] ? zp + atan_q30(i) : zp - atan_q30(i);
    always_ff @(posedge clk) begin
      if (ce) begin
        cx_r[i] <= x_nxt;
        cy_r[i] <= y_nxt;
        cz_r[i] <= z_nxt;
        cf_r[i] <= fp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sin_r <= clamp_q30(cy_r[CORDIC_STEPS-1]);
      cos_r <= cf_r[CORDIC_STEPS-1] ? -clamp_q30(cx_r[CORDIC_STEPS-1])
                                    : clamp_q30(cx_r[CORDIC_STEPS-1]);
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;
endmodule
`default_nettype wire

// ===== hdl/hde_angle.sv =====
// Pipelined square roots of a and 1-a followed by a vectoring CORDIC for the central angle.
`default_nettype none
module hde_angle import hde_pkg::*; (
  input  wire logic        clk,
  input  wire logic        ce,
  input  wire logic [60:0] a_i,
  output logic      [30:0] ang_o
);
  logic [30:0] qa_r [0:30];
  logic [60:0] ra_r [0:30];
  logic [30:0] qb_r [0:30];
  logic [60:0] rb_r [0:30];
  cw_t         vx_r [0:CORDIC_STEPS-1];
  cw_t         vy_r [0:CORDIC_STEPS-1];
  cw_t         vz_r [0:CORDIC_STEPS-1];
  logic [30:0] ang_r;
  logic [60:0] b_in;

  assign b_in = Q_ONE_SQ - a_i;

  // One root bit per stage, most significant first; remainder is v - q*q.
  for (genvar k = 0; k < 31; k++) begin : g_sqrt
    localparam int B = 30 - k;
    logic [30:0] qap, qbp;
    logic [60:0] rap, rbp;
    logic [62:0] ta, tb;
    logic        take_a, take_b;
    if (k == 0) begin : g_first
      assign qap = '0;
      assign qbp = '0;
      assign rap = a_i;
      assign rbp = b_in;
    end else begin : g_next
      assign qap = qa_r[k-1];
      assign qbp = qb_r[k-1];
      assign rap = ra_r[k-1];
      assign rbp = rb_r[k-1];
    end
    assign ta = (63'(qap) << (B + 1)) + (63'd1 << (2 * B));
    assign tb = (63'(qbp) << (B + 1)) + (63'd1 << (2 * B));
    assign take_a = 63'(rap) >= ta;
    assign take_b = 63'(rbp) >= tb;
    always_ff @(posedge clk) begin
      if (ce) begin
        qa_r[k] <= take_a ? (qap | (31'd1 << B)) : qap;
        ra_r[k] <= take_a ? 61'(63'(rap) - ta) : rap;
        qb_r[k] <= take_b ? (qbp | (31'd1 << B)) : qbp;
        rb_r[k] <= take_b ? 61'(63'(rbp) - tb) : rbp;
      end
    end
  end

  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_vec
    cw_t xp, yp, zp;
    if (j == 0) begin : g_first
      assign xp = $signed({3'b000, qb_r[30]});
      assign yp = $signed({3'b000, qa_r[30]});
      assign zp = '0;
    end else begin : g_next
      assign xp = vx_r[j-1];
      assign yp = vy_r[j-1];
      assign zp = vz_r[j-1];
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        if (!yp[33]) begin
          vx_r[j] <= xp + (yp >>> j);
          vy_r[j] <= yp - (xp >>> j);
          vz_r[j] <= zp + atan_q30(j);
        end else begin
          vx_r[j] <= xp - (yp >>> j);
          vy_r[j] <= yp + (xp >>> j);
          vz_r[j] <= zp - atan_q30(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ang_r <= vz_r[CORDIC_STEPS-1][33] ? '0 : vz_r[CORDIC_STEPS-1][30:0];
    end
  end

  assign ang_o = ang_r;
endmodule
`default_nettype wire

// ===== hdl/haversine_distance_eta_unit.sv =====
// Haversine great-circle distance and arrival time, fully pipelined.
// The in_ channel carries two positions in signed microdegrees and a signed
// ground speed in 0.01 km/h; each transfer yields exactly one transfer on the
// out_ channel with the distance in metres, the arrival time in seconds and a
// moving flag in out_tuser. The sphere radius in km is written through
// cfg_we/cfg_wdata; the user must write it only while no item is in flight,
// as the block itself does not enforce this; reset loads 6371. One item is
// accepted per cycle while in_tready is high: four 35-stage sine/cosine
// CORDICs, two 31-stage square roots, a 32-stage vectoring CORDIC and a
// 34-stage divider all advance together under one pipeline enable.
// The result register is backed by a one-entry skid buffer. When the receiver
// stalls, the next result lands in the skid buffer; only when that is also
// full does in_tready drop and the whole pipeline hold, losing nothing.
// Synchronous active-low reset empties the pipeline and both output entries.
`default_nettype none
module haversine_distance_eta_unit import hde_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // from_lat[27:0], from_lon[56:28], to_lat[84:57], to_lon[113:85],
  // ground_speed[129:114], zero pad[135:130]
  input  wire logic [135:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // distance_m[24:0], eta_seconds[56:25], zero pad[63:57]
  output logic      [63:0]  out_tdata,
  // moving[0]
  output logic      [0:0]   out_tuser,
  input  wire logic         cfg_we,
  input  wire logic [12:0]  cfg_wdata
);
  localparam int DLY  = SC_LAT + MQ_LAT + ANG_LAT + 2;
  localparam int VEND = DLY + 36;

  logic ce;
  logic signed [27:0] from_lat, to_lat;
  logic signed [28:0] from_lon, to_lon;
  logic [12:0] radius_r;
  logic [23:0] rk_r;
  logic [VEND:0] vld_r;
  logic [15:0] spd_r [0:DLY];
  logic signed [30:0] ha_r, hb_r, hc_r, hd_r;
  q30_t s_lat, s_lon, c_unused0, c_unused1, s_unused0, s_unused1, cl1, cl2;
  logic [61:0] pcc1_r, sq1_r;
  logic        ncc1_r;
  q30_t        sn1_r;
  q30_t        cc2_r, sn2_r;
  logic [61:0] sq2_r, pm3_r, sq3_r, sq4_r, sq5_r;
  logic        nm3_r;
  q30_t        sn3_r, t4_r, sn4_r;
  logic signed [63:0] u5_r;
  logic signed [64:0] a_sum;
  logic [60:0] a6_r;
  logic [30:0] ang;
  logic [54:0] dp_r;
  logic [55:0] ds;
  logic [24:0] dist_r;
  logic [15:0] spd_a;
  logic        mv_nxt;
  logic [14:0] v_nxt;
  logic [33:0] n3_r;
  logic [14:0] v3_r;
  logic        mv3_r;
  logic [24:0] dist3_r;
  logic [33:0] dq_r   [0:33];
  logic [14:0] drem_r [0:33];
  logic [33:0] dn_r   [0:33];
  logic [14:0] dv_r   [0:33];
  logic        dmv_r  [0:33];
  logic [24:0] dd_r   [0:33];
  logic [57:0] e_r;
  logic [57:0] out_data_r, skid_data_r;
  logic        out_valid_r, skid_valid_r;

  assign from_lat = in_tdata[27:0];
  assign from_lon = in_tdata[56:28];
  assign to_lat   = in_tdata[84:57];
  assign to_lon   = in_tdata[113:85];

  // The pipeline moves whenever the skid entry is free.
  assign ce        = !skid_valid_r;
  assign in_tready = ce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (cfg_we) begin
      radius_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rk_r <= 24'(radius_r) * 24'd2000;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[VEND-1:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ha_r <= 31'(to_lat) - 31'(from_lat);
      hb_r <= 31'(to_lon) - 31'(from_lon);
      hc_r <= {{2{from_lat[27]}}, from_lat, 1'b0};
      hd_r <= {{2{to_lat[27]}}, to_lat, 1'b0};
      spd_r[0] <= in_tdata[129:114];
      for (int k = 1; k <= DLY; k++) begin
        spd_r[k] <= spd_r[k-1];
      end
    end
  end

  hde_sincos u_sc_dlat (.clk(clk), .ce(ce), .h_i(ha_r), .sin_o(s_lat), .cos_o(c_unused0));
  hde_sincos u_sc_dlon (.clk(clk), .ce(ce), .h_i(hb_r), .sin_o(s_lon), .cos_o(c_unused1));
  hde_sincos u_sc_lat1 (.clk(clk), .ce(ce), .h_i(hc_r), .sin_o(s_unused0), .cos_o(cl1));
  hde_sincos u_sc_lat2 (.clk(clk), .ce(ce), .h_i(hd_r), .sin_o(s_unused1), .cos_o(cl2));

  // a = sin^2(dlat/2) + round(sin(dlon/2) * round(cos1*cos2)) * sin(dlon/2), in Q60.
  assign a_sum = $signed({3'b000, sq5_r}) + 65'(u5_r);

  always_ff @(posedge clk) begin
    if (ce) begin
      pcc1_r <= 62'(cl1[31] ? 31'(-cl1) : cl1[30:0]) * 62'(cl2[31] ? 31'(-cl2) : cl2[30:0]);
      ncc1_r <= cl1[31] ^ cl2[31];
      sq1_r  <= 62'(s_lat[31] ? 31'(-s_lat) : s_lat[30:0])
              * 62'(s_lat[31] ? 31'(-s_lat) : s_lat[30:0]);
      sn1_r  <= s_lon;
      cc2_r  <= ncc1_r ? -q30_t'((pcc1_r + 62'd536870912) >> 30)
                       : q30_t'((pcc1_r + 62'd536870912) >> 30);
      sq2_r  <= sq1_r;
      sn2_r  <= sn1_r;
      pm3_r  <= 62'(sn2_r[31] ? 31'(-sn2_r) : sn2_r[30:0])
              * 62'(cc2_r[31] ? 31'(-cc2_r) : cc2_r[30:0]);
      nm3_r  <= sn2_r[31] ^ cc2_r[31];
      sq3_r  <= sq2_r;
      sn3_r  <= sn2_r;
      t4_r   <= nm3_r ? -q30_t'((pm3_r + 62'd536870912) >> 30)
                      : q30_t'((pm3_r + 62'd536870912) >> 30);
      sq4_r  <= sq3_r;
      sn4_r  <= sn3_r;
      u5_r   <= 64'(t4_r) * 64'(sn4_r);
      sq5_r  <= sq4_r;
      if (a_sum[64]) begin
        a6_r <= '0;
      end else if (a_sum > $signed({4'b0000, Q_ONE_SQ})) begin
        a6_r <= Q_ONE_SQ;
      end else begin
        a6_r <= a_sum[60:0];
      end
    end
  end

  hde_angle u_angle (.clk(clk), .ce(ce), .a_i(a6_r), .ang_o(ang));

  assign ds     = 56'(dp_r) + 56'd536870912;
  assign spd_a  = spd_r[DLY];
  assign mv_nxt = !spd_a[15] && (|spd_a[14:0]);
  assign v_nxt  = mv_nxt ? spd_a[14:0] : 15'd1;

  always_ff @(posedge clk) begin
    if (ce) begin
      dp_r    <= 55'(rk_r) * 55'(ang);
      dist_r  <= ds[55] ? '1 : ds[54:30];
      n3_r    <= 34'(dist_r) * 34'd360 + 34'(v_nxt >> 1);
      v3_r    <= v_nxt;
      mv3_r   <= mv_nxt;
      dist3_r <= dist_r;
    end
  end

  // Restoring divider, one quotient bit per stage.
  for (genvar k = 0; k < 34; k++) begin : g_div
    logic [33:0] qp, np;
    logic [14:0] rp, vp;
    logic        mp;
    logic [24:0] dp;
    logic [15:0] rs;
    logic        ge;
    if (k == 0) begin : g_first
      assign qp = '0;
      assign rp = '0;
      assign np = n3_r;
      assign vp = v3_r;
      assign mp = mv3_r;
      assign dp = dist3_r;
    end else begin : g_next
      assign qp = dq_r[k-1];
      assign rp = drem_r[k-1];
      assign np = dn_r[k-1];
      assign vp = dv_r[k-1];
      assign mp = dmv_r[k-1];
      assign dp = dd_r[k-1];
    end
    assign rs = {rp, np[33-k]};
    assign ge = rs >= {1'b0, vp};
    always_ff @(posedge clk) begin
      if (ce) begin
        dq_r[k]   <= {qp[32:0], ge};
        drem_r[k] <= ge ? 15'(rs - {1'b0, vp}) : rs[14:0];
        dn_r[k]   <= np;
        dv_r[k]   <= vp;
        dmv_r[k]  <= mp;
        dd_r[k]   <= dp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      e_r[24:0]  <= dd_r[33];
      e_r[56:25] <= !dmv_r[33] ? 32'd0 : ((|dq_r[33][33:32]) ? '1 : dq_r[33][31:0]);
      e_r[57]    <= dmv_r[33];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (ce) begin
      if (!out_valid_r || out_tready) begin
        out_valid_r <= vld_r[VEND];
      end else if (vld_r[VEND]) begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_tready) begin
      skid_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      if (!out_valid_r || out_tready) begin
        out_data_r <= e_r;
      end else begin
        skid_data_r <= e_r;
      end
    end else if (out_tready) begin
      out_data_r <= skid_data_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_data_r[56:0]};
  assign out_tuser  = out_data_r[57];

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds data while the output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_tready && vld_r[VEND]))
    else $error("skid entry filled without a stalled output and an arriving result");

  a_idle_eta: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata[56:25] == 32'd0))
    else $error("nonzero arrival time reported while not moving");
endmodule
`default_nettype wire
